// File: src/assert_macros.svh
// Assertion macros for the checker file of the LBP stream block.
// Plain text macros only; no other definitions live here.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is seen
`define ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lbp_pkg.sv
// Shared types and constants of the 3x3 LBP stream operator.
// No dependencies; the cell, top level, checker and testbench import this package.
package lbp_pkg;

  // Frame limits and field widths
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int PIX_W        = 8;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int PROW_W       = ROW_W + 1;
  localparam int FW_W         = 11;
  localparam int FH_W         = 13;
  localparam int CFG_W        = 13;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Window and output queue geometry
  localparam int WIN_N        = 3;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    kind_t              kind;
    logic [PIX_W-1:0]   pixel;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0]   lbp_code;
    logic [COL_W-1:0]   out_column;
    logic [ROW_W-1:0]   out_row;
    logic               last;
  } out_beat_t;

endpackage

// File: src/lbp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled, read every cycle (old data on a collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/lbp_cell.sv
// One pixel cell of the 3x3 window chain: holds a pixel, hands it to its
// left neighbor on each shift and compares it with the centre. Uses lbp_pkg.
module lbp_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [lbp_pkg::PIX_W-1:0] pix_in,
  input  logic [lbp_pkg::PIX_W-1:0] centre,
  output logic [lbp_pkg::PIX_W-1:0] pix,
  output logic                      ge
);
  import lbp_pkg::*;

  // Take the neighbor's pixel on a window step
  always_ff @(posedge clk) begin
    if (shift) begin
      pix <= pix_in;
    end
  end

  // Flag a neighbor not darker than the centre
  assign ge = (pix >= centre);

endmodule

// File: src/lbp_3x3_stream_operator.sv
// Top level of the 3x3 local binary pattern stream operator.
// Depends on lbp_pkg, lbp_ram (two line buffers) and lbp_cell (window chain).
//
// Channel  Side  Handshake              Payload
// pix      in    pix_valid / pix_stall  pix_beat: kind, pixel
// code     out   code_valid/code_stall  code_beat: lbp_code, out_column, out_row, last
// config   in    wr_en                  wr_index, wr_data
//
// One beat per clock: a pixel or flush beat is taken every cycle while pix_stall is low.
// A code reaches the code channel from the beat that releases it through registered
// steps: line buffer read, window shift, neighbor compare into a four-entry queue.
// pix_stall rises when the queue plus codes in flight would fill it, and for one
// cycle after the last pixel of a single-row frame (an internal window step).
// Synchronous reset clears counters, valids and the queue; line buffers and
// window are not cleared.
module lbp_3x3_stream_operator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pix_valid,
  output logic                      pix_stall,
  input  lbp_pkg::in_beat_t         pix_beat,
  output logic                      code_valid,
  input  logic                      code_stall,
  output lbp_pkg::out_beat_t        code_beat,
  input  logic                      wr_en,
  input  lbp_pkg::reg_index_t       wr_index,
  input  logic [lbp_pkg::CFG_W-1:0] wr_data
);
  import lbp_pkg::*;

  // Configuration (held as clamped, effective sizes)
  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [FW_W-1:0]   width_next;
  logic [FH_W-1:0]   height_next;
  logic [FW_W-1:0]   width_m1;
  logic [FH_W-1:0]   height_m1;

  // Frame position counters
  logic [COL_W-1:0]  push_col;
  logic [PROW_W-1:0] push_row;
  logic [COL_W-1:0]  emit_col;
  logic [ROW_W-1:0]  emit_row;
  logic              frame_full;
  logic              pad_pending;

  // Step decode
  logic              pix_take;
  logic              is_pixel;
  logic              push;
  logic              emit;
  logic              col_last;
  logic              row_last;
  logic              last_pixel;
  logic              emit_col_last;
  logic              emit_last;
  logic [7:0]        emit_mask;
  logic [FIFO_CNT_W-1:0] credit_used;

  // Read stage
  logic              a_valid;
  logic              a_emit;
  logic [COL_W-1:0]  a_col;
  logic [PIX_W-1:0]  a_pix;
  logic [7:0]        a_mask;
  logic [COL_W-1:0]  a_out_col;
  logic [ROW_W-1:0]  a_out_row;
  logic              a_last;
  logic              fwd;
  logic [PIX_W-1:0]  fwd_older;
  logic [PIX_W-1:0]  fwd_newer;
  logic [PIX_W-1:0]  older_q;
  logic [PIX_W-1:0]  newer_q;
  logic [PIX_W-1:0]  older_eff;
  logic [PIX_W-1:0]  newer_eff;

  // Compare stage
  logic              b_valid;
  logic [7:0]        b_mask;
  logic [COL_W-1:0]  b_out_col;
  logic [ROW_W-1:0]  b_out_row;
  logic              b_last;
  logic [PIX_W-1:0]  new_col [WIN_N];
  logic [PIX_W-1:0]  win_pix [WIN_N][WIN_N];
  logic              win_ge  [WIN_N][WIN_N];
  logic [7:0]        code_bits;

  // Output queue
  out_beat_t             fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic                  code_take;

  // Clamp register writes to the legal frame size
  always_comb begin
    if (wr_data[FW_W-1:0] == '0) begin
      width_next = FW_W'(1);
    end else if (wr_data[FW_W-1:0] > FW_W'(MAX_WIDTH)) begin
      width_next = FW_W'(MAX_WIDTH);
    end else begin
      width_next = wr_data[FW_W-1:0];
    end
    if (wr_data[FH_W-1:0] == '0) begin
      height_next = FH_W'(1);
    end else if (wr_data[FH_W-1:0] > FH_W'(MAX_HEIGHT)) begin
      height_next = FH_W'(MAX_HEIGHT);
    end else begin
      height_next = wr_data[FH_W-1:0];
    end
  end

  assign width_m1  = frame_width - FW_W'(1);
  assign height_m1 = frame_height - FH_W'(1);

  // Hold input while the queue could overflow or a pad step runs
  assign credit_used = fifo_cnt + FIFO_CNT_W'(a_emit) + FIFO_CNT_W'(b_valid);
  assign pix_stall   = pad_pending || (credit_used >= FIFO_CNT_W'(FIFO_DEPTH));
  assign pix_take    = pix_valid && !pix_stall;
  assign is_pixel    = (pix_beat.kind == KIND_PIXEL);

  // A pixel steps the window until the frame is in, a flush steps it after
  assign push = pad_pending || (pix_take && (is_pixel ? !frame_full : frame_full));
  assign emit = push && ((push_row >= PROW_W'(2)) ||
                         ((push_row == PROW_W'(1)) && (push_col != '0)));

  assign col_last      = (FW_W'(push_col) == width_m1);
  assign row_last      = (FH_W'(push_row) == height_m1);
  assign last_pixel    = push && !pad_pending && is_pixel && col_last && row_last;
  assign emit_col_last = (FW_W'(emit_col) == width_m1);
  assign emit_last     = emit_col_last && (FH_W'(emit_row) == height_m1);

  // Mask neighbors outside the frame: NW N NE E SE S SW W from bit 0
  always_comb begin
    logic north;
    logic south;
    logic east;
    logic west;
    north = (emit_row != '0);
    south = (FH_W'(emit_row) != height_m1);
    east  = !emit_col_last;
    west  = (emit_col != '0);
    emit_mask = {west, south && west, south, south && east,
                 east, north && east, north, north && west};
  end

  // Configuration and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(RESET_WIDTH);
      frame_height <= FH_W'(RESET_HEIGHT);
      push_col     <= '0;
      push_row     <= '0;
      emit_col     <= '0;
      emit_row     <= '0;
      frame_full   <= 1'b0;
      pad_pending  <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FRAME_WIDTH:  frame_width  <= width_next;
        REG_FRAME_HEIGHT: frame_height <= height_next;
        default:          frame_width  <= frame_width;
      endcase
      push_col    <= '0;
      push_row    <= '0;
      emit_col    <= '0;
      emit_row    <= '0;
      frame_full  <= 1'b0;
      pad_pending <= 1'b0;
    end else if (emit && emit_last) begin
      // Drop back to the start of a new frame
      push_col    <= '0;
      push_row    <= '0;
      emit_col    <= '0;
      emit_row    <= '0;
      frame_full  <= 1'b0;
      pad_pending <= 1'b0;
    end else begin
      if (push) begin
        if (col_last) begin
          push_col <= '0;
          push_row <= push_row + PROW_W'(1);
        end else begin
          push_col <= push_col + COL_W'(1);
        end
      end
      if (emit) begin
        if (emit_col_last) begin
          emit_col <= '0;
          emit_row <= emit_row + ROW_W'(1);
        end else begin
          emit_col <= emit_col + COL_W'(1);
        end
      end
      if (last_pixel) begin
        frame_full  <= 1'b1;
        pad_pending <= (frame_height == FH_W'(1));
      end else if (pad_pending) begin
        pad_pending <= 1'b0;
      end
    end
  end

  // Line buffers: older holds row y-2, newer row y-1 at the push column
  lbp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
    .clk   (clk),
    .we    (a_valid),
    .waddr (a_col),
    .wdata (newer_eff),
    .raddr (push_col),
    .rdata (older_q)
  );

  lbp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_ram (
    .clk   (clk),
    .we    (a_valid),
    .waddr (a_col),
    .wdata (a_pix),
    .raddr (push_col),
    .rdata (newer_q)
  );

  // Bypass the write of the step before when it hits the same column
  assign older_eff = fwd ? fwd_older : older_q;
  assign newer_eff = fwd ? fwd_newer : newer_q;

  // Read-stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_emit  <= 1'b0;
      fwd     <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= push;
      a_emit  <= emit;
      fwd     <= push && a_valid && (a_col == push_col);
      b_valid <= a_emit;
    end
  end

  // Read-stage and compare-stage payload
  always_ff @(posedge clk) begin
    a_col     <= push_col;
    a_pix     <= pix_beat.pixel;
    a_mask    <= emit_mask;
    a_out_col <= emit_col;
    a_out_row <= emit_row;
    a_last    <= emit_last;
    fwd_older <= newer_eff;
    fwd_newer <= a_pix;
    b_mask    <= a_mask;
    b_out_col <= a_out_col;
    b_out_row <= a_out_row;
    b_last    <= a_last;
  end

  // New window column: rows y-2, y-1, y of the pushed position
  assign new_col[0] = older_eff;
  assign new_col[1] = newer_eff;
  assign new_col[2] = a_pix;

  // Window chain: each row shifts right to left on every step
  for (genvar r = 0; r < WIN_N; r++) begin : g_row
    for (genvar c = 0; c < WIN_N; c++) begin : g_col
      logic [PIX_W-1:0] feed;
      if (c == WIN_N - 1) begin : g_edge
        assign feed = new_col[r];
      end else begin : g_inner
        assign feed = win_pix[r][c+1];
      end
      lbp_cell u_cell (
        .clk    (clk),
        .shift  (a_valid),
        .pix_in (feed),
        .centre (win_pix[1][1]),
        .pix    (win_pix[r][c]),
        .ge     (win_ge[r][c])
      );
    end
  end

  // Gather the compare bits in neighbor order and mask the frame edges
  assign code_bits = {win_ge[1][0], win_ge[2][0], win_ge[2][1], win_ge[2][2],
                      win_ge[1][2], win_ge[0][2], win_ge[0][1], win_ge[0][0]} & b_mask;

  // Output queue control
  assign code_valid = (fifo_cnt != '0);
  assign code_take  = code_valid && !code_stall;
  assign code_beat  = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (b_valid) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (code_take) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      fifo_cnt <= fifo_cnt + FIFO_CNT_W'(b_valid) - FIFO_CNT_W'(code_take);
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (b_valid) begin
      fifo_mem[wr_ptr] <= '{lbp_code:   code_bits,
                            out_column: b_out_col,
                            out_row:    b_out_row,
                            last:       b_last};
    end
  end

endmodule

// File: src/lbp_checker.sv
// Port-level checks for the LBP stream operator, bound to the top level.
// Depends on lbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lbp_checker (
  input logic               clk,
  input logic               rst,
  input logic               code_valid,
  input logic               code_stall,
  input lbp_pkg::out_beat_t code_beat
);
  import lbp_pkg::*;

  // A stalled code beat stays put
  `ASSERT_NEXT(a_code_hold, clk, rst, code_valid && code_stall, code_valid && $stable(code_beat), "code beat changed under stall")

  // Top row has no northern neighbors
  `ASSERT_IMPLY(a_top_row_mask, clk, rst, code_valid && (code_beat.out_row == '0), code_beat.lbp_code[2:0] == 3'b000, "north bits set on top row")

  // Left column has no western neighbors
  `ASSERT_IMPLY(a_left_col_mask, clk, rst, code_valid && (code_beat.out_column == '0), (code_beat.lbp_code[0] == 1'b0) && (code_beat.lbp_code[7:6] == 2'b00), "west bits set on left column")

  // Reset empties the output queue
  `ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !code_valid, "code valid right after reset")

endmodule

bind lbp_3x3_stream_operator lbp_checker u_lbp_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for lbp_3x3_stream_operator: streams pixel and flush beats
// through the block and compares each code beat with an in-bench LBP predictor.
// Depends on lbp_pkg for the beat structs, kinds, register indexes and limits.
module testbench;
  import lbp_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 9;
  localparam int HIST_DEPTH      = 2 * MAX_WIDTH + 9;
  localparam int SETTLE_CYCLES   = 12;
  localparam int POWER_ON_PIXELS = 660;
  localparam int RANDOM_BEATS    = 650;
  localparam int MAX_REPORTS     = 10;
  localparam int CYCLE_LIMIT     = 1500000;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 pix_valid  = 1'b0;
  logic                 pix_stall;
  in_beat_t             pix_beat   = '0;
  logic                 code_valid;
  logic                 code_stall = 1'b0;
  out_beat_t            code_beat;
  logic                 wr_en      = 1'b0;
  reg_index_t           wr_index   = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     wr_data    = '0;

  // Predictor state: frame geometry, pixel history and raster counters
  logic [FW_W-1:0]      width_reg  = FW_W'(RESET_WIDTH);
  logic [FH_W-1:0]      height_reg = FH_W'(RESET_HEIGHT);
  logic [PIX_W-1:0]     pix_hist [HIST_DEPTH];
  int                   rx_count   = 0;
  int                   code_col   = 0;
  int                   code_row   = 0;

  out_beat_t            code_queue [$];
  bit                   no_idle         = 1'b0;
  int                   stall_left      = 0;
  int                   cycle_count     = 0;
  int                   mismatch_count  = 0;
  int                   codes_checked   = 0;
  int                   frames_closed   = 0;
  int                   pixels_sent     = 0;
  int                   flushes_sent    = 0;
  int                   effective_beats = 0;

  lbp_3x3_stream_operator uut (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix_beat   (pix_beat),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_beat  (code_beat),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Mostly short gaps, a few long ones, none while no_idle is set
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 24);
  endfunction

  // Zero sizes act as 1, oversize values clamp to the maximum
  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  function automatic int frame_pixels();
    return eff_width() * eff_height();
  endfunction

  // Neighbor bit: set when inside the frame and not darker than the center
  function automatic bit not_below(input int x, input int y, input logic [PIX_W-1:0] centre);
    int w;
    w = eff_width();
    if (x < 0 || y < 0 || x >= w || y >= eff_height()) return 1'b0;
    return pix_hist[(y * w + x) % HIST_DEPTH] >= centre;
  endfunction

  // Build the code at the emit position and advance it; wrap to a new frame after the last
  function automatic out_beat_t next_code();
    out_beat_t        code;
    int               x, y, pos;
    logic [PIX_W-1:0] centre;
    x = code_col;
    y = code_row;
    pos = y * eff_width() + x;
    centre = pix_hist[pos % HIST_DEPTH];
    // bit order NW, N, NE, E, SE, S, SW, W from bit 0 upward
    code.lbp_code = {not_below(x - 1, y,     centre), not_below(x - 1, y + 1, centre),
                     not_below(x,     y + 1, centre), not_below(x + 1, y + 1, centre),
                     not_below(x + 1, y,     centre), not_below(x + 1, y - 1, centre),
                     not_below(x,     y - 1, centre), not_below(x - 1, y - 1, centre)};
    code.out_column = x[COL_W-1:0];
    code.out_row    = y[ROW_W-1:0];
    code.last       = (pos + 1 == frame_pixels());
    if (code.last) begin
      rx_count = 0;
      code_col = 0;
      code_row = 0;
    end else begin
      code_col++;
      if (code_col >= eff_width()) begin
        code_col = 0;
        code_row++;
      end
    end
    return code;
  endfunction

  // Apply one accepted beat; return 1 when it releases a code
  function automatic bit predict_beat(input in_beat_t beat, output out_beat_t code);
    int n;
    code = '0;
    if (beat.kind == KIND_PIXEL) begin
      // drop pixels while the finished frame still has codes pending
      if (rx_count >= frame_pixels()) return 1'b0;
      n = rx_count;
      pix_hist[n % HIST_DEPTH] = beat.pixel;
      rx_count = n + 1;
      if (n < eff_width() + 1) return 1'b0;
    end else if (rx_count < frame_pixels()) begin
      // flush before the frame is complete does nothing
      return 1'b0;
    end
    code = next_code();
    return 1'b1;
  endfunction

  // Drive one beat at the falling edge and hold it until the block takes it
  task automatic send_beat(input kind_t kind, input logic [PIX_W-1:0] value);
    in_beat_t  beat;
    out_beat_t code;
    int        gap;
    beat.kind  = kind;
    beat.pixel = value;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix_beat  <= beat;
    do @(posedge clk); while (pix_stall);
    if (kind == KIND_PIXEL) pixels_sent++;
    else flushes_sent++;
    if (predict_beat(beat, code)) code_queue.push_back(code);
  endtask

  task automatic release_input();
    @(negedge clk);
    pix_valid <= 1'b0;
  endtask

  // Write a register once every expected code is out and the pipeline has settled
  task automatic write_reg(input reg_index_t index, input logic [CFG_W-1:0] data);
    release_input();
    while (code_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= data;
    @(posedge clk);
    case (index)
      REG_FRAME_WIDTH:  width_reg  = data[FW_W-1:0];
      REG_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
      default: ;
    endcase
    rx_count = 0;
    code_col = 0;
    code_row = 0;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // Release pending codes; optionally slip in pixels that must be dropped
  task automatic flush_frame(input int noise_pct);
    while (rx_count != 0) begin
      if ($urandom_range(0, 99) < noise_pct) send_beat(KIND_PIXEL, PIX_W'($urandom));
      send_beat(KIND_FLUSH, PIX_W'($urandom));
      effective_beats++;
    end
  endtask

  // Set geometry, stream one frame of random pixels, then flush it out.
  // abort_at >= 0 cuts the frame short after that many pixels, with no flush.
  task automatic run_frame(input int w, input int h, input int noise_pct, input int abort_at);
    int         lo, spread;
    logic [1:0] spare;
    spare = 2'($urandom_range(0, 3));
    // upper data bits above the width register must be ignored
    if ($urandom_range(0, 1)) begin
      write_reg(REG_FRAME_WIDTH, {spare, w[FW_W-1:0]});
      write_reg(REG_FRAME_HEIGHT, h[FH_W-1:0]);
    end else begin
      write_reg(REG_FRAME_HEIGHT, h[FH_W-1:0]);
      write_reg(REG_FRAME_WIDTH, {spare, w[FW_W-1:0]});
    end
    // narrow value ranges make ties between neighbors common
    case ($urandom_range(0, 3))
      0:       spread = 3;
      1:       spread = 15;
      default: spread = 255;
    endcase
    lo = $urandom_range(0, 255 - spread);
    for (int k = 0; k < frame_pixels(); k++) begin
      if (k == abort_at) return;
      if ($urandom_range(0, 99) < noise_pct) send_beat(KIND_FLUSH, PIX_W'($urandom));
      send_beat(KIND_PIXEL, PIX_W'(lo + $urandom_range(0, spread)));
      effective_beats++;
    end
    flush_frame(noise_pct);
  endtask

  // Reset geometry is 640x480: stream part of a frame to see the start of the first row of codes
  task automatic test_power_on_geometry();
    for (int k = 0; k < POWER_ON_PIXELS; k++) send_beat(KIND_PIXEL, PIX_W'($urandom));
  endtask

  // 1x1 via zero sizes with early flush and dropped pixel, then two 3x3 frames
  task automatic test_corner_frames();
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    send_beat(KIND_FLUSH, 8'hFF);
    send_beat(KIND_PIXEL, 8'h80);
    send_beat(KIND_PIXEL, 8'h7F);
    flush_frame(0);
    write_reg(REG_FRAME_WIDTH, CFG_W'(3));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
    // dark center inside a white ring
    for (int k = 0; k < 9; k++) send_beat(KIND_PIXEL, (k == 4) ? 8'h00 : 8'hFF);
    flush_frame(0);
    // white center, equal neighbors everywhere else
    for (int k = 0; k < 9; k++) send_beat(KIND_PIXEL, (k == 4) ? 8'hFF : 8'h5A);
    flush_frame(0);
  endtask

  // Mostly complete small frames, some cut short, with ignored beats mixed in
  task automatic test_random_frames();
    int start, w, h, abort_at, noise_pct;
    start = effective_beats;
    while (effective_beats - start < RANDOM_BEATS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 19))
        0: begin
          w = $urandom_range(0, 1);
          h = $urandom_range(0, 4);
        end
        1: begin
          w = $urandom_range(17, 64);
          h = $urandom_range(1, 4);
        end
        2: begin
          w = $urandom_range(1, 3);
          h = $urandom_range(0, 24);
        end
        default: begin
          w = $urandom_range(1, 16);
          h = $urandom_range(1, 8);
        end
      endcase
      noise_pct = $urandom_range(0, 1) ? 0 : $urandom_range(3, 12);
      abort_at = -1;
      if ($urandom_range(0, 9) == 0)
        abort_at = $urandom_range(0, (w == 0 ? 1 : w) * (h == 0 ? 1 : h) - 1);
      run_frame(w, h, noise_pct, abort_at);
    end
    no_idle = 1'b0;
  endtask

  // Code channel backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      code_stall <= 1'b1;
      stall_left--;
    end else begin
      code_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  task automatic log_mismatch(input string what, input out_beat_t want, input out_beat_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: want code %02h col %0d row %0d last %0b, got code %02h col %0d row %0d last %0b",
               $time, what, want.lbp_code, want.out_column, want.out_row, want.last,
               got.lbp_code, got.out_column, got.out_row, got.last);
  endtask

  // Compare every accepted code beat with the oldest prediction
  always @(posedge clk) begin : check_codes
    out_beat_t want;
    out_beat_t got;
    if (!rst && code_valid && !code_stall) begin
      got = code_beat;
      codes_checked++;
      if (got.last) frames_closed++;
      if (code_queue.size() == 0) begin
        log_mismatch("unexpected code", '0, got);
      end else begin
        want = code_queue.pop_front();
        if (got.lbp_code !== want.lbp_code || got.out_column !== want.out_column ||
            got.out_row !== want.out_row || got.last !== want.last)
          log_mismatch("code mismatch", want, got);
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
    $display("lbp_3x3_stream_operator: mismatch");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_power_on_geometry();
    test_corner_frames();
    test_random_frames();

    // Drain the code channel, then give the pipeline time to show strays
    release_input();
    while (code_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (code_queue.size() != 0) begin
      $display("%0d expected codes never arrived", code_queue.size());
      mismatch_count += code_queue.size();
    end

    $display("streamed %0d pixel and %0d flush beats, checked %0d codes over %0d closed frames",
             pixels_sent, flushes_sent, codes_checked, frames_closed);
    $display("frames ran from the 640-wide power-on size through 1x1 and 3x3 to random sizes");
    if (mismatch_count == 0) begin
      $display("lbp_3x3_stream_operator: match");
    end else begin
      $display("lbp_3x3_stream_operator: mismatch");
    end
    $finish;
  end

endmodule
